// ----- rtl/core/framed_motor_target_parser_unit_assert.svh -----
// Assertion macros shared by the framed motor target parser RTL.
`ifndef FRAMED_MOTOR_TARGET_PARSER_UNIT_ASSERT_SVH
`define FRAMED_MOTOR_TARGET_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Checks a property on the rising clock edge, disabled while reset is active.
`define FMTP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on the rising clock edge at all times, reset included.
`define FMTP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FMTP_ASSERT(label, clk, rst_n, prop, msg)
`define FMTP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- rtl/core/fmtp_pkg.sv -----
// Types and constants of the framed motor target parser.
`timescale 1ns / 1ps
`default_nettype none

package fmtp_pkg;

	// Field and datapath types.
	typedef logic [7:0]  char_t;
	typedef logic [15:0] steps_t;
	typedef logic [9:0]  scale_t;
	typedef logic [9:0]  mag_t;
	typedef logic [25:0] prod_t;
	typedef logic [26:0] target_t;
	typedef logic [3:0]  cnt_t;
	typedef logic [4:0]  div_cnt_t;
	typedef logic [0:0]  cfg_idx_t;
	typedef logic [15:0] cfg_data_t;

	// Framing and digit characters.
	localparam char_t ChStart  = 8'h53;
	localparam char_t ChFinish = 8'h46;
	localparam char_t ChZero   = 8'h30;
	localparam char_t ChNine   = 8'h39;

	// Payload layout.
	localparam int   PayloadMax = 8;
	localparam cnt_t PayloadFull = cnt_t'(PayloadMax);
	localparam cnt_t FieldLen    = 4'd4;

	// The divider retires one quotient bit per cycle over the product width.
	localparam int       ProdW   = $bits(prod_t);
	localparam div_cnt_t DivLast = div_cnt_t'(ProdW - 1);

	// Configuration register indexes and reset values.
	localparam cfg_idx_t CfgStepsPerTurn = 1'b0;
	localparam cfg_idx_t CfgFullScale    = 1'b1;
	localparam steps_t   StepsReset      = 16'd1600;
	localparam scale_t   ScaleReset      = 10'd999;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_DIR,
		S_DIGIT,
		S_MUL,
		S_DIV,
		S_SIGN,
		S_WRITE
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/core/framed_motor_target_parser_unit.sv -----
// Framed motor target parser: character framing, field parsing and scaling.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received character per transaction. 'S' opens a frame, other
// characters fill an eight-entry payload, and 'F' closes the frame and emits
// one transaction with two signed step targets (zero when no frame was open).
// Characters other than 'F' are taken without a stall. An 'F' that closes a
// frame keeps the input stalled while each of the two fields runs a short
// digit parse (one character per cycle), one 10 x 16 multiply and a 26-step
// restoring divider by full_scale. An 'F' with no frame open goes straight
// to the write state. The result sits in an output register, so characters
// that do not close a frame are still accepted while a result waits to be
// taken; a further 'F' is parsed but waits in the write state until it frees.
module framed_motor_target_parser_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	// Character input channel.
	input  wire                  in_valid,
	output logic                 in_stall,
	input  fmtp_pkg::char_t      rx_char,
	// Target output channel.
	output logic                 out_valid,
	input  wire                  out_stall,
	output fmtp_pkg::target_t    target_first,
	output fmtp_pkg::target_t    target_second,
	// Configuration write port.
	input  wire                  cfg_we,
	input  fmtp_pkg::cfg_idx_t   cfg_index,
	input  fmtp_pkg::cfg_data_t  cfg_data
);

`include "framed_motor_target_parser_unit_assert.svh"

	fmtp_pkg::state_t   state_q, state_d;
	fmtp_pkg::steps_t   steps_q;
	fmtp_pkg::scale_t   scale_q;
	logic               in_frame_q;
	fmtp_pkg::cnt_t     count_q;
	fmtp_pkg::char_t    payload_q [fmtp_pkg::PayloadMax];
	logic               fld_q;
	fmtp_pkg::cnt_t     ptr_q;
	fmtp_pkg::div_cnt_t div_cnt_q;
	logic               neg_q;
	fmtp_pkg::mag_t     mag_q;
	fmtp_pkg::prod_t    quo_q;
	fmtp_pkg::scale_t   rem_q;
	fmtp_pkg::target_t  tgt0_q, tgt1_q;
	logic               out_valid_q;
	fmtp_pkg::target_t  out_first_q, out_second_q;

	logic               in_accept;
	logic               out_free;
	fmtp_pkg::cnt_t     base;
	fmtp_pkg::cnt_t     field_end;
	fmtp_pkg::char_t    cur_char;
	logic               cur_is_digit;
	logic               digit_go;
	fmtp_pkg::mag_t     digit_val;
	fmtp_pkg::scale_t   divisor;
	logic [10:0]        trial;
	logic [10:0]        trial_sub;
	logic               trial_ge;
	fmtp_pkg::target_t  signed_q;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Field addressing and digit decode for the character under the pointer.
	assign base         = fld_q ? fmtp_pkg::FieldLen : 4'd0;
	assign field_end    = base + fmtp_pkg::FieldLen;
	assign cur_char     = payload_q[ptr_q[2:0]];
	assign cur_is_digit = (cur_char >= fmtp_pkg::ChZero) && (cur_char <= fmtp_pkg::ChNine);
	assign digit_go     = (ptr_q < count_q) && (ptr_q != field_end) && cur_is_digit;
	assign digit_val    = fmtp_pkg::mag_t'(cur_char - fmtp_pkg::ChZero);

	// Shared divider step: a divisor of zero counts as one.
	assign divisor   = (scale_q == '0) ? 10'd1 : scale_q;
	assign trial     = {rem_q, quo_q[fmtp_pkg::ProdW-1]};
	assign trial_ge  = trial >= {1'b0, divisor};
	assign trial_sub = trial - {1'b0, divisor};

	// Sign is applied to the truncated quotient.
	assign signed_q = neg_q ? fmtp_pkg::target_t'(-{1'b0, quo_q}) : {1'b0, quo_q};

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fmtp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and input stall.
	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != fmtp_pkg::S_IDLE);
		unique case (state_q)
			fmtp_pkg::S_IDLE: begin
				if (in_accept && rx_char == fmtp_pkg::ChFinish) begin
					state_d = in_frame_q ? fmtp_pkg::S_DIR : fmtp_pkg::S_WRITE;
				end
			end
			fmtp_pkg::S_DIR: begin
				state_d = fmtp_pkg::S_DIGIT;
			end
			fmtp_pkg::S_DIGIT: begin
				if (!digit_go) begin
					state_d = fmtp_pkg::S_MUL;
				end
			end
			fmtp_pkg::S_MUL: begin
				state_d = fmtp_pkg::S_DIV;
			end
			fmtp_pkg::S_DIV: begin
				if (div_cnt_q == fmtp_pkg::DivLast) begin
					state_d = fmtp_pkg::S_SIGN;
				end
			end
			fmtp_pkg::S_SIGN: begin
				state_d = fld_q ? fmtp_pkg::S_WRITE : fmtp_pkg::S_DIR;
			end
			fmtp_pkg::S_WRITE: begin
				if (out_free) begin
					state_d = fmtp_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fmtp_pkg::S_IDLE;
			end
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= fmtp_pkg::StepsReset;
			scale_q <= fmtp_pkg::ScaleReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fmtp_pkg::CfgStepsPerTurn: steps_q <= cfg_data;
				fmtp_pkg::CfgFullScale:    scale_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Frame tracking, sequencer counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			count_q     <= '0;
			fld_q       <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A written result raises valid; a taken one clears it.
			if (state_q == fmtp_pkg::S_WRITE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				fmtp_pkg::S_IDLE: begin
					if (in_accept) begin
						if (rx_char == fmtp_pkg::ChStart) begin
							in_frame_q <= 1'b1;
							count_q    <= '0;
						end else if (rx_char == fmtp_pkg::ChFinish) begin
							in_frame_q <= 1'b0;
							fld_q      <= 1'b0;
						end else if (in_frame_q && count_q < fmtp_pkg::PayloadFull) begin
							count_q <= count_q + 4'd1;
						end
					end
				end
				fmtp_pkg::S_MUL: begin
					div_cnt_q <= '0;
				end
				fmtp_pkg::S_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
				end
				fmtp_pkg::S_SIGN: begin
					fld_q <= 1'b1;
				end
				fmtp_pkg::S_WRITE: begin
					if (out_free) begin
						count_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload store and arithmetic datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			fmtp_pkg::S_IDLE: begin
				if (in_accept) begin
					if (rx_char == fmtp_pkg::ChFinish && !in_frame_q) begin
						tgt0_q <= '0;
						tgt1_q <= '0;
					end else if (rx_char != fmtp_pkg::ChStart && rx_char != fmtp_pkg::ChFinish
							&& in_frame_q && count_q < fmtp_pkg::PayloadFull) begin
						payload_q[count_q[2:0]] <= rx_char;
					end
				end
			end
			fmtp_pkg::S_DIR: begin
				neg_q <= (base < count_q) && (payload_q[base[2:0]] == fmtp_pkg::ChZero);
				ptr_q <= base + 4'd1;
				mag_q <= '0;
			end
			fmtp_pkg::S_DIGIT: begin
				if (digit_go) begin
					mag_q <= (mag_q << 3) + (mag_q << 1) + digit_val;
					ptr_q <= ptr_q + 4'd1;
				end
			end
			fmtp_pkg::S_MUL: begin
				quo_q <= fmtp_pkg::prod_t'(mag_q) * fmtp_pkg::prod_t'(steps_q);
				rem_q <= '0;
			end
			fmtp_pkg::S_DIV: begin
				rem_q <= trial_ge ? trial_sub[9:0] : trial[9:0];
				quo_q <= {quo_q[fmtp_pkg::ProdW-2:0], trial_ge};
			end
			fmtp_pkg::S_SIGN: begin
				if (fld_q) begin
					tgt1_q <= signed_q;
				end else begin
					tgt0_q <= signed_q;
				end
			end
			fmtp_pkg::S_WRITE: begin
				if (out_free) begin
					out_first_q  <= tgt0_q;
					out_second_q <= tgt1_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign target_first  = out_first_q;
	assign target_second = out_second_q;

	// The payload count never passes the store depth.
	`FMTP_ASSERT(a_count_bound, clk, arst_n, count_q <= fmtp_pkg::PayloadFull, "payload count overflow")

	// An accepted frame close always starts the sequencer.
	`FMTP_ASSERT(a_finish_starts, clk, arst_n, (in_accept && rx_char == fmtp_pkg::ChFinish) |=> (state_q != fmtp_pkg::S_IDLE), "frame close did not start the sequencer")

	// A new result only appears out of the write state.
	`FMTP_ASSERT(a_result_source, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == fmtp_pkg::S_WRITE), "result raised outside the write state")

	// With no frame open and the sequencer idle, the payload is empty.
	`FMTP_ASSERT(a_idle_empty, clk, arst_n, (state_q == fmtp_pkg::S_IDLE && !in_frame_q) |-> (count_q == 4'd0), "stale payload outside a frame")

endmodule

`default_nettype wire
